/* design/msp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the supersampled mandelbrot pixel
// Holds register indexes, reset values and the controller/datapath structs.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ITER_WIDTH_DEF    = 12;
    localparam int MAX_DIVISIONS_DEF = 8;

    // configuration register indexes
    localparam logic [1:0] REG_SS_ENABLE = 2'd0;
    localparam logic [1:0] REG_DIVISIONS = 2'd1;
    localparam logic [1:0] REG_SPACING   = 2'd2;
    localparam logic [1:0] REG_BUDGET    = 2'd3;

    localparam int CFG_DATA_WIDTH = 31;

    // register reset values
    localparam logic        RST_SS_ENABLE = 1'b1;
    localparam logic [3:0]  RST_DIVISIONS = 4'd4;
    localparam logic [30:0] RST_SPACING   = 31'd268435;
    localparam logic [11:0] RST_BUDGET    = 12'd255;

    // commands from controller to datapath
    typedef struct packed {
        logic load_pixel;   // capture centre, set up grid
        logic div_step;     // one step of the step or average divider
        logic avg_start;    // begin average division
        logic sample_start; // load sample point, clear z
        logic iterate;      // one complex iteration
        logic sample_done;  // accumulate sample result
        logic next_row;     // advance imag index
        logic next_col;     // advance real index, reset imag
    } msp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic escaped;      // current sample has escaped
        logic budget_hit;   // iteration counter reached budget
        logic row_last;     // imag index at last grid point
        logic col_last;     // real index at last grid point
    } msp_stat_t;

endpackage

/* design/mandelbrot_supersampled_pixel_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_supersampled_pixel_top: escape-time pixel with supersampling
// Works on one pixel at a time: a new pixel is taken only after the result
// of the last one has been loaded into the output slot.
// Reset: synchronous active-low aresetn clears control and loads register
// reset values; it also empties the output slot.
// ----------------------------------------------------------------------------
module mandelbrot_supersampled_pixel_top
    import msp_pkg::*;
#(
    parameter int ITER_WIDTH    = ITER_WIDTH_DEF,
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // centre_real[31:0], centre_imag[63:32], screen_col[75:64], screen_row[87:76]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // col_out[11:0], row_out[23:12], red[31:24], green[39:32], blue[47:40],
    // escaped_samples[54:48]
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic        ss_en_reg;
    logic [3:0]  div_reg;
    logic [30:0] spc_reg;
    logic [11:0] bud_reg;
    logic [23:0] pos_reg;
    logic [55:0] out_reg;
    logic        ovalid_reg;

    msp_cmd_t  cmd;
    msp_stat_t stat;
    logic      busy, result_load, in_beat, out_free;
    logic [7:0] red, green, blue;
    logic [6:0] nesc;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ss_en_reg <= RST_SS_ENABLE;
            div_reg   <= RST_DIVISIONS;
            spc_reg   <= RST_SPACING;
            bud_reg   <= RST_BUDGET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SS_ENABLE: ss_en_reg <= cfg_data[0];
                REG_DIVISIONS: div_reg   <= cfg_data[3:0];
                REG_SPACING:   spc_reg   <= cfg_data[30:0];
                REG_BUDGET:    bud_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;

    // screen position held through the pixel
    always_ff @(posedge aclk) begin
        if (in_beat) pos_reg <= s_tdata[87:64];
    end

    // output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (result_load) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
        if (result_load) out_reg <= {1'b0, nesc, blue, green, red, pos_reg};
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    msp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_beat     (in_beat),
        .out_free    (out_free),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .result_load (result_load)
    );

    msp_datapath #(
        .ITER_WIDTH    (ITER_WIDTH),
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_dp (
        .aclk            (aclk),
        .cmd             (cmd),
        .stat            (stat),
        .centre_real     (s_tdata[31:0]),
        .centre_imag     (s_tdata[63:32]),
        .ss_enable       (ss_en_reg),
        .divisions       (div_reg),
        .spacing         (spc_reg),
        .budget          (bud_reg),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .escaped_samples (nesc)
    );

endmodule

/* design/msp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_ctrl: sequencer for the mandelbrot pixel
// Steps through step division, sample grid, iteration loop and averaging.
// ----------------------------------------------------------------------------
module msp_ctrl
    import msp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_beat,
    input  logic      out_free,
    input  msp_stat_t stat,
    output msp_cmd_t  cmd,
    output logic      busy,
    output logic      result_load
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIVSTP = 3'd1;
    localparam logic [2:0] ST_SAMPLE = 3'd2;
    localparam logic [2:0] ST_ITER   = 3'd3;
    localparam logic [2:0] ST_NEXT   = 3'd4;
    localparam logic [2:0] ST_DIVAVG = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // both divisions take this many single-bit steps
    localparam int DIV_STEPS = 40;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    cmd.load_pixel = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_DIVSTP;
                end
            end
            ST_DIVSTP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                cmd.sample_start = 1'b1;
                state_next       = ST_ITER;
            end
            ST_ITER: begin
                if (stat.escaped || stat.budget_hit) begin
                    cmd.sample_done = 1'b1;
                    state_next      = ST_NEXT;
                end else begin
                    cmd.iterate = 1'b1;
                end
            end
            ST_NEXT: begin
                if (!stat.row_last) begin
                    cmd.next_row = 1'b1;
                    state_next   = ST_SAMPLE;
                end else if (!stat.col_last) begin
                    cmd.next_col = 1'b1;
                    state_next   = ST_SAMPLE;
                end else begin
                    cmd.avg_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIVAVG;
                end
            end
            ST_DIVAVG: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* design/msp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_datapath: fixed-point iteration unit, grid walker and divider
// One complex step per cycle; a shared restoring divider does step and mean.
// ----------------------------------------------------------------------------
module msp_datapath
    import msp_pkg::*;
#(
    parameter int ITER_WIDTH    = ITER_WIDTH_DEF,
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
) (
    input  logic                          aclk,
    input  msp_cmd_t                      cmd,
    output msp_stat_t                     stat,
    input  logic signed [31:0]            centre_real,
    input  logic signed [31:0]            centre_imag,
    input  logic                          ss_enable,
    input  logic [3:0]                    divisions,
    input  logic [30:0]                   spacing,
    input  logic [11:0]                   budget,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic [6:0]                    escaped_samples
);

    localparam int CW     = COORD_WIDTH_DEF;
    localparam int FB     = CW - 4;
    localparam int W      = CW + 2;          // working width for sums
    localparam int PW     = 2 * CW;          // product width
    localparam int IDX_W  = $clog2(MAX_DIVISIONS + 1);
    localparam int NESC_W = $clog2((MAX_DIVISIONS + 1) * (MAX_DIVISIONS + 1) + 1);
    localparam int DIV_W  = 40;              // divider word
    localparam int SUM_W  = 40;
    localparam logic [ITER_WIDTH-1:0] ITER_LIMIT = '1;

    localparam logic signed [W-1:0] CMAX = W'(signed'({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [W-1:0] CMIN = -CMAX - W'(1);
    localparam logic signed [W-1:0] TWO  = W'(2) <<< FB;

    // saturate a wide value into the coordinate range
    function automatic logic signed [W-1:0] clampw(input logic signed [W+1:0] v);
        logic signed [W+1:0] hi, lo;
        hi = (W+2)'(CMAX);
        lo = (W+2)'(CMIN);
        if (v > hi) return CMAX;
        else if (v < lo) return CMIN;
        else return W'(v);
    endfunction

    // truncating signed fixed-point product
    function automatic logic signed [W-1:0] fxmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic          neg;
        logic [CW-1:0] ua, ub;
        logic [PW-1:0] p;
        logic [PW-1:0] m;
        neg = a[CW-1] ^ b[CW-1];
        ua  = a[CW-1] ? CW'(-a) : a;
        ub  = b[CW-1] ? CW'(-b) : b;
        p   = PW'(ua) * PW'(ub);
        m   = p >> FB;
        return neg ? -W'(signed'(m[W-1:0])) : W'(signed'(m[W-1:0]));
    endfunction

    // pixel registers
    logic signed [CW-1:0] cr_reg, ci_reg;
    logic signed [CW-1:0] sr_reg, si_reg;   // current sample point
    logic signed [W-1:0]  half_reg, step_reg;
    logic [IDX_W-1:0]     dlim_reg, ci_idx_reg, ri_idx_reg;
    logic [ITER_WIDTH-1:0] bud_reg, it_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic                 esc_reg;          // point left the |re|,|im| < 2 box
    logic [SUM_W-1:0]     total_reg;
    logic [NESC_W-1:0]    nesc_reg;
    // divider
    logic [DIV_W-1:0]     quo_reg, rem_reg, dsr_reg;
    logic [7:0]           avg_reg;

    // effective divisions
    logic [3:0] d_eff;
    always_comb begin
        if (!ss_enable) d_eff = 4'd0;
        else if (divisions == 4'd0) d_eff = 4'd1;
        else if (32'(divisions) > MAX_DIVISIONS) d_eff = 4'(MAX_DIVISIONS);
        else d_eff = divisions;
    end

    // sample coordinate from centre, half and index
    function automatic logic signed [CW-1:0] grid_pt(input logic signed [CW-1:0] c,
                                                     input logic signed [W-1:0] h,
                                                     input logic signed [W-1:0] s,
                                                     input logic [IDX_W-1:0] i);
        logic signed [W-1:0] a;
        logic signed [W+8:0] off;
        logic signed [W+10:0] tot;
        a   = clampw((W+2)'(c) - (W+2)'(h));
        off = (W+9)'(s) * (W+9)'(signed'({1'b0, i}));
        tot = (W+11)'(a) + (W+11)'(off);
        if (tot > (W+11)'(CMAX)) return CW'(CMAX);
        else if (tot < (W+11)'(CMIN)) return CW'(CMIN);
        else return CW'(tot);
    endfunction

    // step straight from the divider on the first sample, held afterwards
    logic signed [W-1:0] step_now;
    assign step_now = (ci_idx_reg == '0 && ri_idx_reg == '0)
                    ? W'(signed'(quo_reg[W-1:0])) : step_reg;

    // iteration arithmetic; the squares of the current point also give its
    // magnitude test, so a new point is tested in the cycle after it is computed
    logic signed [W-1:0] xx, yy, xy, nx, ny;
    logic signed [CW-1:0] nxc, nyc;
    logic                 big, mag, esc_now;
    logic [ITER_WIDTH-1:0] it_inc;
    always_comb begin
        xx  = fxmul(x_reg, x_reg);
        yy  = fxmul(y_reg, y_reg);
        xy  = fxmul(x_reg, y_reg);
        nx  = clampw((W+2)'(clampw((W+2)'(xx) - (W+2)'(yy))) + (W+2)'(sr_reg));
        ny  = clampw((W+2)'(clampw((W+2)'(xy) + (W+2)'(xy))) + (W+2)'(si_reg));
        nxc = CW'(nx);
        nyc = CW'(ny);
        big = (nx >= TWO) || (nx <= -TWO) || (ny >= TWO) || (ny <= -TWO);
        mag = ((W+1)'(xx) + (W+1)'(yy)) >= ((W+1)'(TWO) <<< 1);
        esc_now = esc_reg || mag;
        it_inc = it_reg + ITER_WIDTH'(1);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            cr_reg     <= CW'(signed'(centre_real));
            ci_reg     <= CW'(signed'(centre_imag));
            half_reg   <= W'({1'b0, spacing[30:1]});
            dlim_reg   <= IDX_W'(d_eff);
            bud_reg    <= (32'(budget) > 32'(ITER_LIMIT)) ? ITER_LIMIT
                                                          : ITER_WIDTH'(budget);
            ci_idx_reg <= '0;
            ri_idx_reg <= '0;
            total_reg  <= '0;
            nesc_reg   <= '0;
            // divide 2*half by d
            quo_reg    <= DIV_W'({spacing[30:1], 1'b0});
            rem_reg    <= '0;
            dsr_reg    <= DIV_W'((d_eff == 4'd0) ? 4'd1 : d_eff);
        end
        if (cmd.div_step) begin
            logic [DIV_W:0] trial;
            trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dsr_reg};
            if (!trial[DIV_W]) begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.sample_start) begin
            if (dlim_reg == '0) begin
                sr_reg <= cr_reg;
                si_reg <= ci_reg;
            end else begin
                sr_reg <= grid_pt(cr_reg, half_reg, step_now, ci_idx_reg);
                si_reg <= grid_pt(ci_reg, half_reg, step_now, ri_idx_reg);
            end
            if (ci_idx_reg == '0 && ri_idx_reg == '0) begin
                step_reg <= step_now;
            end
            x_reg   <= '0;
            y_reg   <= '0;
            it_reg  <= '0;
            esc_reg <= 1'b0;
        end
        if (cmd.iterate) begin
            x_reg   <= nxc;
            y_reg   <= nyc;
            it_reg  <= it_inc;
            esc_reg <= big;
        end
        if (cmd.sample_done && esc_now) begin
            total_reg <= total_reg + SUM_W'(it_reg);
            nesc_reg  <= nesc_reg + NESC_W'(1);
        end
        if (cmd.next_row) ri_idx_reg <= ri_idx_reg + IDX_W'(1);
        if (cmd.next_col) begin
            ri_idx_reg <= '0;
            ci_idx_reg <= ci_idx_reg + IDX_W'(1);
        end
        if (cmd.avg_start) begin
            quo_reg <= total_reg;
            rem_reg <= '0;
            dsr_reg <= (nesc_reg == '0) ? DIV_W'(1) : DIV_W'(nesc_reg);
        end
    end

    assign avg_reg         = quo_reg[7:0];
    assign red             = (nesc_reg == '0) ? 8'd0 : 8'(avg_reg * 8'd8);
    assign green           = (nesc_reg == '0) ? 8'd0 : 8'(avg_reg * 8'd6);
    assign blue            = (nesc_reg == '0) ? 8'd0 : 8'(avg_reg * 8'd12);
    assign escaped_samples = 7'(nesc_reg);

    assign stat.escaped    = esc_now;
    assign stat.budget_hit = (it_reg == bud_reg);
    assign stat.row_last   = (ri_idx_reg == dlim_reg);
    assign stat.col_last   = (ci_idx_reg == dlim_reg);

endmodule

/* design/msp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_checker: port-level checks for the mandelbrot pixel block
// Watches the stream handshakes of the top level.
// ----------------------------------------------------------------------------
module msp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // held result stays put while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no new pixel taken right after one is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // a result never appears in the cycle after an input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without work");

    // escaped count of zero means black
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[54:48] == 7'd0 |-> m_tdata[47:24] == 24'd0)
        else $error("non-black pixel with no escapes");

endmodule

bind mandelbrot_supersampled_pixel_top msp_checker u_msp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
